// ----- hdl/infix_expression_evaluator_defines.svh -----
// ---------------------------------------------------------------------------
// Infix expression evaluator - assertion macros
// Shared property forms for the evaluator blocks; clocked on clk,
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define IEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IEE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/iee_pkg.sv -----
// ---------------------------------------------------------------------------
// iee_pkg
// Types, codes and helpers shared by the infix expression evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] word_t;

  // token kinds
  localparam logic ACT_NUM = 1'b0;
  localparam logic ACT_OP  = 1'b1;

  // operator codes
  typedef logic [1:0] op_t;
  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_DIVZERO   = 2'd1;
  localparam status_t ST_MALFORMED = 2'd2;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_MUL,
    MUL_DIV
  } mul_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

  // join the pending term into the running sum
  function automatic word_t fold(input word_t sum, input word_t term, input logic sub);
    fold = sub ? (sum - term) : (sum + term);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/iee_if.sv -----
// ---------------------------------------------------------------------------
// iee_if
// Token and result channels of the evaluator, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface iee_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic signed [iee_pkg::DATA_W-1:0] value;
  logic [1:0]                       op_code;
  logic                             last;

  modport source (output valid, action, value, op_code, last, input ready);
  modport sink   (input valid, action, value, op_code, last, output ready);
endinterface

interface iee_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [iee_pkg::DATA_W-1:0] result;
  logic [1:0]                       status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

`default_nettype wire

// ----- hdl/iee_muldiv.sv -----
// ---------------------------------------------------------------------------
// iee_muldiv
// Shared bit-serial unit: shift-add multiply (low word) and restoring
// signed divide truncating toward zero, one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module iee_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  iee_pkg::md_req_t req,
  input  iee_pkg::word_t   opa,
  input  iee_pkg::word_t   opb,
  output iee_pkg::md_rsp_t rsp,
  output iee_pkg::word_t   result
);

  localparam int W = iee_pkg::DATA_W;

  // control
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [iee_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  // datapath
  iee_pkg::word_t            acc_r, acc_nxt;   // product / partial remainder
  iee_pkg::word_t            sh_r, sh_nxt;     // multiplier / dividend-quotient
  iee_pkg::word_t            opd_r, opd_nxt;   // multiplicand / divisor
  logic                      div_r, div_nxt;
  logic                      neg_r, neg_nxt;

  iee_pkg::word_t            a_mag, b_mag, mul_sum;
  logic [W:0]                rem_sh, diff;

  always_comb begin
    a_mag   = opa[W-1] ? (~opa + 1'b1) : opa;
    b_mag   = opb[W-1] ? (~opb + 1'b1) : opb;
    rem_sh  = {acc_r, sh_r[W-1]};
    diff    = rem_sh - {1'b0, opd_r};
    mul_sum = acc_r + opd_r;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    opd_nxt  = opd_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;

    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      div_nxt  = req.is_div;
      neg_nxt  = opa[W-1] ^ opb[W-1];
      if (req.is_div) begin
        sh_nxt  = a_mag;
        opd_nxt = b_mag;
      end else begin
        sh_nxt  = opb;
        opd_nxt = opa;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (div_r) begin
        if (!diff[W]) begin
          acc_nxt = diff[W-1:0];
          sh_nxt  = {sh_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh[W-1:0];
          sh_nxt  = {sh_r[W-2:0], 1'b0};
        end
      end else begin
        if (sh_r[0]) begin
          acc_nxt = mul_sum;
        end
        opd_nxt = {opd_r[W-2:0], 1'b0};
        sh_nxt  = {1'b0, sh_r[W-1:1]};
      end
      if (cnt_r == iee_pkg::CNT_W'(W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    opd_r <= opd_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = div_r ? (neg_r ? (~sh_r + 1'b1) : sh_r) : acc_r;

endmodule

`default_nettype wire

// ----- hdl/infix_expression_evaluator.sv -----
// ---------------------------------------------------------------------------
// infix_expression_evaluator
// Token-serial evaluator of +, -, *, / expressions with two precedence
// levels; keeps a running sum and a pending product term.
// ---------------------------------------------------------------------------
//
//  channel   dir  word                              handshake
//  in_tok    in   action, value, op_code, last      valid/ready
//  out_res   out  result, status                    valid/ready
//
//  Operator tokens and numbers with no pending * or / are taken in S_IDLE.
//  A number that completes a * or / (nonzero divisor) waits in S_BUSY while
//  the bit-serial multiply/divide unit retires one bit per cycle.
//  A last token that went through that unit is written out from S_FIN.
//  Reset (rst_n low, synchronous) starts a fresh expression, output empty.
//  A last token is held off while the output register is full and not
//  being taken; other tokens pass (in S_IDLE) regardless of out_res.ready.
// ---------------------------------------------------------------------------
`default_nettype none
`include "infix_expression_evaluator_defines.svh"

module infix_expression_evaluator (
  input  logic      clk,
  input  logic      rst_n,
  iee_in_if.sink    in_tok,
  iee_out_if.source out_res
);

  iee_pkg::state_t    state_r, state_nxt;
  iee_pkg::word_t     sum_r, sum_nxt;
  iee_pkg::word_t     term_r, term_nxt;
  logic               addk_r, addk_nxt;
  iee_pkg::mul_kind_t mulk_r, mulk_nxt;
  logic               expect_r, expect_nxt;
  iee_pkg::status_t   err_r, err_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  iee_pkg::word_t     result_r, result_nxt;
  iee_pkg::status_t   status_r, status_nxt;

  iee_pkg::md_req_t   md_req;
  iee_pkg::md_rsp_t   md_rsp;
  iee_pkg::word_t     md_result;

  logic               accept, slot_free, emit, go_busy;
  iee_pkg::status_t   fin_st;
  iee_pkg::word_t     fin_res;

  iee_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .opa    (term_r),
    .opb    (in_tok.value),
    .rsp    (md_rsp),
    .result (md_result)
  );

  assign slot_free = !out_valid_r || out_res.ready;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    term_nxt      = term_r;
    addk_nxt      = addk_r;
    mulk_nxt      = mulk_r;
    expect_nxt    = expect_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    result_nxt    = result_r;
    status_nxt    = status_r;
    md_req        = '0;
    in_tok.ready  = 1'b0;
    accept        = 1'b0;
    emit          = 1'b0;
    go_busy       = 1'b0;
    fin_st        = iee_pkg::ST_OK;
    fin_res       = '0;

    case (state_r)
      iee_pkg::S_IDLE: begin
        in_tok.ready = !in_tok.last || slot_free;
        accept       = in_tok.valid && in_tok.ready;
        if (accept) begin
          if (in_tok.action == iee_pkg::ACT_NUM) begin
            if (!expect_r) begin
              if (err_r == iee_pkg::ST_OK) err_nxt = iee_pkg::ST_MALFORMED;
            end else begin
              expect_nxt = 1'b0;
              mulk_nxt   = iee_pkg::MUL_NONE;
              case (mulk_r)
                iee_pkg::MUL_MUL: begin
                  md_req.start  = 1'b1;
                  md_req.is_div = 1'b0;
                  go_busy       = 1'b1;
                end
                iee_pkg::MUL_DIV: begin
                  if (in_tok.value == '0) begin
                    if (err_r == iee_pkg::ST_OK) err_nxt = iee_pkg::ST_DIVZERO;
                    term_nxt = '0;
                  end else begin
                    md_req.start  = 1'b1;
                    md_req.is_div = 1'b1;
                    go_busy       = 1'b1;
                  end
                end
                default: term_nxt = in_tok.value;
              endcase
            end
          end else begin
            if (expect_r) begin
              if (err_r == iee_pkg::ST_OK) err_nxt = iee_pkg::ST_MALFORMED;
            end else begin
              expect_nxt = 1'b1;
              case (in_tok.op_code)
                iee_pkg::OP_MUL: mulk_nxt = iee_pkg::MUL_MUL;
                iee_pkg::OP_DIV: mulk_nxt = iee_pkg::MUL_DIV;
                default: begin
                  sum_nxt  = iee_pkg::fold(sum_r, term_r, addk_r);
                  term_nxt = '0;
                  addk_nxt = in_tok.op_code[0];
                  mulk_nxt = iee_pkg::MUL_NONE;
                end
              endcase
            end
          end

          if (go_busy) begin
            state_nxt = iee_pkg::S_BUSY;
            last_nxt  = in_tok.last;
          end else if (in_tok.last) begin
            // sum is unchanged whenever the expression ends on a number
            emit = 1'b1;
            if (err_nxt != iee_pkg::ST_OK) fin_st = err_nxt;
            else if (expect_nxt)           fin_st = iee_pkg::ST_MALFORMED;
            if (fin_st == iee_pkg::ST_OK)
              fin_res = iee_pkg::fold(sum_r, term_nxt, addk_r);
          end
        end
      end

      iee_pkg::S_BUSY: begin
        if (md_rsp.done) begin
          term_nxt  = md_result;
          state_nxt = last_r ? iee_pkg::S_FIN : iee_pkg::S_IDLE;
        end
      end

      iee_pkg::S_FIN: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = iee_pkg::S_IDLE;
          fin_st    = err_r;
          if (err_r == iee_pkg::ST_OK)
            fin_res = iee_pkg::fold(sum_r, term_r, addk_r);
        end
      end

      default: state_nxt = iee_pkg::S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      result_nxt    = fin_res;
      status_nxt    = fin_st;
      sum_nxt       = '0;
      term_nxt      = '0;
      addk_nxt      = 1'b0;
      mulk_nxt      = iee_pkg::MUL_NONE;
      expect_nxt    = 1'b1;
      err_nxt       = iee_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iee_pkg::S_IDLE;
      sum_r       <= '0;
      term_r      <= '0;
      addk_r      <= 1'b0;
      mulk_r      <= iee_pkg::MUL_NONE;
      expect_r    <= 1'b1;
      err_r       <= iee_pkg::ST_OK;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      term_r      <= term_nxt;
      addk_r      <= addk_nxt;
      mulk_r      <= mulk_nxt;
      expect_r    <= expect_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    status_r <= status_nxt;
  end

  assign out_res.valid  = out_valid_r;
  assign out_res.result = result_r;
  assign out_res.status = status_r;

  `IEE_ASSERT_IMP(a_err_zero_result, out_valid_r && (status_r != iee_pkg::ST_OK),
                  result_r == '0, "result not zero on error status")
  `IEE_ASSERT_IMP(a_done_in_busy, md_rsp.done, state_r == iee_pkg::S_BUSY,
                  "mul/div done outside busy state")
  `IEE_ASSERT_IMP(a_emit_free, emit, slot_free, "result written over a pending word")
  `IEE_ASSERT_NXT(a_start_busy, md_req.start, md_rsp.busy, "mul/div unit did not start")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench - infix expression evaluator
// Sends token streams (numbers and + - * / operators) through the token
// channel and checks each result word against an in-bench evaluator of the
// same expression or, for some directed cases, a fixed answer: a short
// directed list of cases, then random expressions with broken ones mixed in,
// with random idling, a long output hold and a drain pause.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import iee_pkg::*;

  localparam int RANDOM_TOKENS = 1150;
  localparam int HOLD_CYCLES   = 400;
  // worst case is ~1200 tokens plus gaps and stalls; well under this
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic  action;
    word_t value;
    op_t   op;
    logic  last;
  } token_t;

  typedef struct packed {
    word_t   result;
    status_t status;
  } answer_t;

  typedef struct packed {
    token_t  tok;
    logic    fixed;
    answer_t ans;
  } row_t;

  logic clk;
  logic rst_n;

  iee_in_if  in_tok ();
  iee_out_if out_res ();

  infix_expression_evaluator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tok  (in_tok),
    .out_res (out_res)
  );

  // evaluator state
  word_t     calc_sum;
  word_t     calc_term;
  logic      calc_sub;
  mul_kind_t calc_mul;
  logic      calc_want_num;
  status_t   calc_err;

  answer_t pending_answers[$];
  row_t    directed_rows[$];
  token_t  draft[$];

  int   tokens_sent;
  int   results_seen;
  int   flagged_seen;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   stall_left;
  logic no_idle;
  logic hold_requested;
  logic hold_started;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void clear_calc();
    calc_sum      = '0;
    calc_term     = '0;
    calc_sub      = 1'b0;
    calc_mul      = MUL_NONE;
    calc_want_num = 1'b1;
    calc_err      = ST_OK;
  endfunction

  function automatic void note_error(input status_t code);
    if (calc_err == ST_OK)
      calc_err = code;
  endfunction

  function automatic word_t joined_sum();
    return calc_sub ? calc_sum - calc_term : calc_sum + calc_term;
  endfunction

  // advances the evaluator by one token; returns 1 when the token closes an expression
  function automatic bit evaluate_token(input token_t t, output answer_t ans);
    longint quo;
    ans = '0;
    if (t.action == ACT_NUM) begin
      if (!calc_want_num) begin
        note_error(ST_MALFORMED);
      end else begin
        case (calc_mul)
          MUL_MUL: calc_term = calc_term * t.value;
          MUL_DIV: begin
            if (t.value == '0) begin
              note_error(ST_DIVZERO);
              calc_term = '0;
            end else begin
              // 64-bit quotient so that min / -1 wraps instead of overflowing
              quo = longint'($signed(calc_term)) / longint'($signed(t.value));
              calc_term = quo[31:0];
            end
          end
          default: calc_term = t.value;
        endcase
        calc_mul      = MUL_NONE;
        calc_want_num = 1'b0;
      end
    end else begin
      if (calc_want_num) begin
        note_error(ST_MALFORMED);
      end else begin
        if (t.op == OP_MUL) begin
          calc_mul = MUL_MUL;
        end else if (t.op == OP_DIV) begin
          calc_mul = MUL_DIV;
        end else begin
          calc_sum  = joined_sum();
          calc_term = '0;
          calc_sub  = (t.op == OP_SUB);
          calc_mul  = MUL_NONE;
        end
        calc_want_num = 1'b1;
      end
    end
    if (!t.last)
      return 1'b0;
    if (calc_want_num)
      note_error(ST_MALFORMED);
    ans.status = calc_err;
    ans.result = (calc_err == ST_OK) ? joined_sum() : '0;
    clear_calc();
    return 1'b1;
  endfunction

  function automatic token_t number_token(input word_t v);
    token_t t;
    t.action = ACT_NUM;
    t.value  = v;
    t.op     = op_t'($urandom_range(3));  // don't care on numbers
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic token_t operator_token(input op_t op);
    token_t t;
    t.action = ACT_OP;
    t.value  = $urandom;                  // don't care on operators
    t.op     = op;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      2:       v = 32'h8000_0000;
      3:       v = 32'h7fff_ffff;
      4, 5:    v = $urandom_range(20);
      6:       v = '0 - $urandom_range(20);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void add_row(input logic action, input word_t value, input op_t op,
                                  input logic last, input logic fixed = 1'b0,
                                  input word_t res = '0, input status_t st = ST_OK);
    row_t r;
    r.tok.action = action;
    r.tok.value  = value;
    r.tok.op     = op;
    r.tok.last   = last;
    r.fixed      = fixed;
    r.ans.result = res;
    r.ans.status = st;
    directed_rows.push_back(r);
  endfunction

  // fills draft with one expression; most are well formed, some broken, a few pure noise
  task automatic build_expression();
    int     terms;
    int     shape;
    int     spot;
    token_t t;
    draft.delete();
    shape = $urandom_range(99);
    if (shape >= 95) begin
      terms = $urandom_range(1, 5);
      repeat (terms) begin
        t.action = 1'($urandom_range(1));
        t.value  = $urandom;
        t.op     = op_t'($urandom_range(3));
        t.last   = ($urandom_range(3) == 0);
        draft.push_back(t);
      end
    end else begin
      terms = $urandom_range(1, 6);
      for (int i = 0; i < terms; i++) begin
        if (i != 0)
          draft.push_back(operator_token(op_t'($urandom_range(3))));
        draft.push_back(number_token(pick_operand()));
      end
      if (shape >= 88) begin
        // dangling operator at the end
        draft.push_back(operator_token(op_t'($urandom_range(3))));
      end else if (shape >= 80) begin
        // repeat a token so two of the same kind follow each other
        spot = $urandom_range(draft.size() - 1);
        t = draft[spot];
        draft.insert(spot, t);
      end
    end
    t = draft.pop_back();
    t.last = 1'b1;
    draft.push_back(t);
  endtask

  task automatic issue_token(input token_t t, input logic fixed, input answer_t fixed_ans);
    answer_t got;
    while (!no_idle && $urandom_range(99) < 7) begin
      in_tok.valid <= 1'b0;
      @(posedge clk);
    end
    in_tok.valid   <= 1'b1;
    in_tok.action  <= t.action;
    in_tok.value   <= t.value;
    in_tok.op_code <= t.op;
    in_tok.last    <= t.last;
    @(posedge clk);
    while (!in_tok.ready)
      @(posedge clk);
    tokens_sent++;
    if (evaluate_token(t, got))
      pending_answers.push_back(fixed ? fixed_ans : got);
  endtask

  // token side
  initial begin
    int  random_tokens;
    bit  paused;
    rst_n           <= 1'b0;
    in_tok.valid    <= 1'b0;
    in_tok.action   <= ACT_NUM;
    in_tok.value    <= '0;
    in_tok.op_code  <= OP_ADD;
    in_tok.last     <= 1'b0;
    tokens_sent     = 0;
    random_tokens   = 0;
    paused          = 1'b0;
    no_idle         = 1'b0;
    hold_requested  = 1'b0;
    clear_calc();

    // single numbers at the extremes; op_code is a don't care here
    add_row(ACT_NUM, 32'h7fff_ffff, OP_DIV, 1'b1, 1'b1, 32'h7fff_ffff, ST_OK);
    add_row(ACT_NUM, 32'h8000_0000, OP_MUL, 1'b1, 1'b1, 32'h8000_0000, ST_OK);
    // operator where a number is due
    add_row(ACT_OP,  32'h0,         OP_ADD, 1'b1, 1'b1, '0, ST_MALFORMED);
    // precedence and wrap: 7 - 100 * max
    add_row(ACT_NUM, 32'd7,         OP_ADD, 1'b0);
    add_row(ACT_OP,  32'hdead_beef, OP_SUB, 1'b0);
    add_row(ACT_NUM, 32'd100,       OP_ADD, 1'b0);
    add_row(ACT_OP,  32'h0,         OP_MUL, 1'b0);
    add_row(ACT_NUM, 32'h7fff_ffff, OP_ADD, 1'b1);
    // division by zero
    add_row(ACT_NUM, 32'd5,         OP_ADD, 1'b0);
    add_row(ACT_OP,  32'h0,         OP_DIV, 1'b0);
    add_row(ACT_NUM, 32'h0,         OP_ADD, 1'b1, 1'b1, '0, ST_DIVZERO);
    // most negative over minus one wraps
    add_row(ACT_NUM, 32'h8000_0000, OP_ADD, 1'b0);
    add_row(ACT_OP,  32'hffff_ffff, OP_DIV, 1'b0);
    add_row(ACT_NUM, 32'hffff_ffff, OP_ADD, 1'b1, 1'b1, 32'h8000_0000, ST_OK);
    // expression ends in an operator
    add_row(ACT_NUM, 32'd3,         OP_ADD, 1'b0);
    add_row(ACT_OP,  32'h0,         OP_ADD, 1'b1, 1'b1, '0, ST_MALFORMED);
    // number where an operator is due
    add_row(ACT_NUM, 32'd1,         OP_ADD, 1'b0);
    add_row(ACT_NUM, 32'd2,         OP_ADD, 1'b1, 1'b1, '0, ST_MALFORMED);
    // first error wins: divide by zero then an out-of-order number
    add_row(ACT_NUM, 32'd1,         OP_ADD, 1'b0);
    add_row(ACT_OP,  32'h0,         OP_DIV, 1'b0);
    add_row(ACT_NUM, 32'h0,         OP_ADD, 1'b0);
    add_row(ACT_NUM, 32'd5,         OP_ADD, 1'b1, 1'b1, '0, ST_DIVZERO);
    // truncation toward zero: -7 / 2
    add_row(ACT_NUM, 32'hffff_fff9, OP_ADD, 1'b0);
    add_row(ACT_OP,  32'h0,         OP_DIV, 1'b0);
    add_row(ACT_NUM, 32'd2,         OP_ADD, 1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue_token(directed_rows[i].tok, directed_rows[i].fixed, directed_rows[i].ans);

    while (random_tokens < RANDOM_TOKENS) begin
      build_expression();
      foreach (draft[i]) begin
        issue_token(draft[i], 1'b0, '0);
        random_tokens++;
        if (random_tokens == 300)
          hold_requested = 1'b1;
        no_idle = (random_tokens >= 450 && random_tokens < 650);
      end
      // drain everything once, mid-run
      if (!paused && random_tokens >= 700) begin
        paused = 1'b1;
        in_tok.valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
          @(posedge clk);
      end
    end
    in_tok.valid <= 1'b0;

    while (pending_answers.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d tokens sent, %0d results checked, %0d of them with an error status",
             tokens_sent, results_seen, flagged_seen);
    $display("covered: random idling, a no-idle stretch, a %0d-cycle output hold, a drain pause",
             HOLD_CYCLES);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // result side: check each word and decide ready for the next cycle
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      stall_left    <= 0;
      hold_started  <= 1'b0;
      results_seen  <= 0;
      flagged_seen  <= 0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        results_seen <= results_seen + 1;
        if (out_res.status != ST_OK)
          flagged_seen <= flagged_seen + 1;
        if (pending_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word: result %0d status %0d",
                     $signed(out_res.result), out_res.status);
        end else begin
          want = pending_answers.pop_front();
          if (out_res.result !== want.result || out_res.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected result %0d status %0d, got result %0d status %0d",
                       $signed(want.result), want.status,
                       $signed(out_res.result), out_res.status);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        out_res.ready <= 1'b0;
      end else if (hold_requested && !hold_started) begin
        hold_started  <= 1'b1;
        stall_left    <= HOLD_CYCLES;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results still awaited",
               cycle_count, pending_answers.size());
      $display("FAILURE");
      $finish;
    end
  end

endmodule

`default_nettype wire
